### src/speed_ramp_with_reversal_unit_macros.svh
// assertion macros for the speed ramp with reversal unit
`ifndef SPEED_RAMP_WITH_REVERSAL_UNIT_MACROS_SVH
`define SPEED_RAMP_WITH_REVERSAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SRRU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("speed ramp check failed");
`define SRRU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("speed ramp check failed");
`else
`define SRRU_ASSERT(lbl, prop)
`define SRRU_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### src/srru_pkg.sv
// types, constants and helper functions of the speed ramp with reversal unit
`timescale 1ns / 1ps

package srru_pkg;

  localparam int SPEED_W = 24;
  localparam int CFG_W   = 24;
  localparam int REQ_W   = 32;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_DECEL = 2'd1;
  localparam logic [1:0] REG_MAX   = 2'd2;

  localparam logic [CFG_W-1:0] ACCEL_RESET = CFG_W'(10000);
  localparam logic [CFG_W-1:0] DECEL_RESET = CFG_W'(10000);
  localparam logic [CFG_W-1:0] MAX_RESET   = {CFG_W{1'b1}};

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET       = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP_NOW  = 3'd3;
  localparam logic [OP_W-1:0] OP_UNLOCK    = 3'd4;
  localparam logic [OP_W-1:0] OP_RECOVER   = 3'd5;

  // input transfer layout
  localparam int S_TDATA_W = ((REQ_W + 3 + 7) / 8) * 8;
  localparam int S_FWD_BIT = REQ_W;
  localparam int S_DRV_BIT = REQ_W + 1;
  localparam int S_GEN_BIT = REQ_W + 2;

  // result transfer layout
  localparam int CMD_W     = 7;
  localparam int RES_W     = 2 * SPEED_W + 3 + CMD_W;
  localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

  // rate * 20 / 1000 == (rate >> 1) / 25, done as a reciprocal multiply
  localparam int                 STEP_SHIFT = 28;
  localparam logic [CFG_W-1:0]   STEP_RECIP = CFG_W'(((64'd1 << STEP_SHIFT) + 64'd24) / 64'd25);
  localparam int                 PROD_W     = 2 * CFG_W - 1;

  typedef struct packed {
    logic clear_error;
    logic disable_driver;
    logic stop_profiled;
    logic run_at_rate;
    logic enable_driver;
    logic set_direction;
    logic stop_now;
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               reversing;
    logic               ramping;
    logic [SPEED_W-1:0] target;
    logic               direction;
    logic [SPEED_W-1:0] speed;
  } res_t;

  function automatic logic [SPEED_W-1:0] rate_step(input logic [CFG_W-1:0] rate);
    logic [PROD_W-1:0] prod;
    logic [SPEED_W-1:0] q;
    prod = PROD_W'(rate[CFG_W-1:1]) * PROD_W'(STEP_RECIP);
    q    = SPEED_W'(prod[PROD_W-1:STEP_SHIFT]);
    if (q == '0) begin
      q = SPEED_W'(1);
    end
    return q;
  endfunction

endpackage

### src/speed_ramp_with_reversal_unit.sv
// stepper speed ramp with ramp-through-zero reversal, one result per transfer
`timescale 1ns / 1ps

// Speed ramp with reversal. Each input transfer carries one operation (tick, set target,
// stop normal, stop immediate, unlock, recover) and yields exactly one result transfer with
// the applied speed, direction, target, flags and one-shot commands for the step generator.
// The operation is decoded and the state and the result register are updated at the
// accepting edge, so a new item is taken every cycle as long as the result register is
// empty or is drained in the same cycle. The result appears in the cycle after
// acceptance. Per-tick step sizes are computed from accel_limit and decel_limit
// when those registers are written, so a tick costs one add, compare and clamp.
module speed_ramp_with_reversal_unit
  import srru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 s_tvalid,
  output logic                 s_tready,
  // requested_speed, requested_forward, driver_is_enabled, generator_running
  input  logic [S_TDATA_W-1:0] s_tdata,
  // operation
  input  logic [OP_W-1:0]      s_tuser,

  output logic                 m_tvalid,
  input  logic                 m_tready,
  // speed_out, direction_out, target_out, ramping, reversing_flag, do_stop_now,
  // do_set_direction, do_enable_driver, do_run_at_rate, do_stop_profiled,
  // do_disable_driver, do_clear_error
  output logic [M_TDATA_W-1:0] m_tdata,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  `include "speed_ramp_with_reversal_unit_macros.svh"

  logic [CFG_W-1:0]   accel_limit;
  logic [CFG_W-1:0]   decel_limit;
  logic [CFG_W-1:0]   max_speed;
  logic [SPEED_W-1:0] step_up;
  logic [SPEED_W-1:0] step_dn;

  logic [SPEED_W-1:0] applied_speed, applied_speed_next;
  logic [SPEED_W-1:0] target_speed, target_speed_next;
  logic               target_dir, target_dir_next;
  logic               cur_dir, cur_dir_next;
  logic               ramp_flag, ramp_flag_next;
  logic               rev_flag, rev_flag_next;

  res_t               res, res_next;
  logic               s_fire;
  logic               cfg_wr;
  logic [1:0]         cfg_sel;

  logic [OP_W-1:0]        op;
  logic signed [REQ_W-1:0] req;
  logic                   req_fwd;
  logic                   drv_en;
  logic                   gen_run;

  logic [SPEED_W-1:0] req_clamped;
  logic [SPEED_W-1:0] set_speed;
  logic               set_dir;
  logic [SPEED_W:0]   up_sum;
  logic [SPEED_W:0]   dn_bound;
  logic [SPEED_W-1:0] tick_speed;
  cmd_t               cmd;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[PADDR_W-1:2];

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_ACCEL: prdata = PDATA_W'(accel_limit);
      REG_DECEL: prdata = PDATA_W'(decel_limit);
      REG_MAX:   prdata = PDATA_W'(max_speed);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit <= ACCEL_RESET;
      decel_limit <= DECEL_RESET;
      max_speed   <= MAX_RESET;
      step_up     <= rate_step(ACCEL_RESET);
      step_dn     <= rate_step(DECEL_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_ACCEL: begin
          accel_limit <= pwdata[CFG_W-1:0];
          step_up     <= rate_step(pwdata[CFG_W-1:0]);
        end
        REG_DECEL: begin
          decel_limit <= pwdata[CFG_W-1:0];
          step_dn     <= rate_step(pwdata[CFG_W-1:0]);
        end
        REG_MAX: max_speed <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  assign op      = s_tuser;
  assign req     = s_tdata[REQ_W-1:0];
  assign req_fwd = s_tdata[S_FWD_BIT];
  assign drv_en  = s_tdata[S_DRV_BIT];
  assign gen_run = s_tdata[S_GEN_BIT];

  // target clamp to 0..max_speed
  always_comb begin
    if (req[REQ_W-1]) begin
      req_clamped = '0;
    end else if (REQ_W'(req) > REQ_W'(max_speed)) begin
      req_clamped = SPEED_W'(max_speed);
    end else begin
      req_clamped = req[SPEED_W-1:0];
    end
  end

  assign up_sum   = {1'b0, applied_speed} + {1'b0, step_up};
  assign dn_bound = {1'b0, target_speed} + {1'b0, step_dn};

  always_comb begin
    applied_speed_next = applied_speed;
    target_speed_next  = target_speed;
    target_dir_next    = target_dir;
    cur_dir_next       = cur_dir;
    ramp_flag_next     = ramp_flag;
    rev_flag_next      = rev_flag;
    cmd                = '0;
    set_speed          = '0;
    set_dir            = target_dir;
    tick_speed         = applied_speed;

    unique case (op) inside
      OP_TICK: begin
        if ((target_dir != cur_dir) || rev_flag) begin
          // ramp down through zero, then flip
          if (applied_speed > step_dn) begin
            tick_speed     = applied_speed - step_dn;
            rev_flag_next  = 1'b1;
            ramp_flag_next = 1'b1;
          end else begin
            tick_speed         = '0;
            if (applied_speed != '0) begin
              ramp_flag_next = 1'b1;
            end
            cmd.stop_now      = 1'b1;
            cmd.set_direction = 1'b1;
            cur_dir_next      = target_dir;
            rev_flag_next     = 1'b0;
          end
        end else if (applied_speed < target_speed) begin
          if (up_sum >= {1'b0, target_speed}) begin
            tick_speed     = target_speed;
            ramp_flag_next = 1'b0;
          end else begin
            tick_speed     = up_sum[SPEED_W-1:0];
            ramp_flag_next = 1'b1;
          end
        end else if (applied_speed > target_speed) begin
          if ({1'b0, applied_speed} <= dn_bound) begin
            tick_speed     = target_speed;
            ramp_flag_next = 1'b0;
          end else begin
            tick_speed     = applied_speed - step_dn;
            ramp_flag_next = 1'b1;
          end
        end else begin
          ramp_flag_next = 1'b0;
        end
        applied_speed_next = tick_speed;
        if (tick_speed != '0) begin
          cmd.enable_driver = !drv_en;
          cmd.run_at_rate   = 1'b1;
        end else begin
          cmd.stop_profiled = gen_run;
        end
      end
      OP_SET, OP_STOP: begin
        if (op == OP_SET) begin
          set_speed = req_clamped;
          set_dir   = req_fwd;
        end
        target_speed_next = set_speed;
        target_dir_next   = set_dir;
        if ((set_dir != cur_dir) && (applied_speed != '0)) begin
          rev_flag_next = 1'b1;
        end
        cmd.enable_driver = (applied_speed == '0) && (set_speed != '0) && !drv_en;
      end
      OP_STOP_NOW, OP_UNLOCK, OP_RECOVER: begin
        target_speed_next  = '0;
        applied_speed_next = '0;
        ramp_flag_next     = 1'b0;
        rev_flag_next      = 1'b0;
        cmd.stop_now       = (op != OP_UNLOCK);
        cmd.disable_driver = (op != OP_STOP_NOW);
        cmd.clear_error    = (op == OP_RECOVER);
      end
      default: ;
    endcase

    res_next.cmd       = cmd;
    res_next.speed     = applied_speed_next;
    res_next.direction = cur_dir_next;
    res_next.target    = target_speed_next;
    res_next.ramping   = ramp_flag_next;
    res_next.reversing = rev_flag_next ||
                         ((target_dir_next != cur_dir_next) && (applied_speed_next != '0));
  end

  // result register: takes a new item while the old result drains
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      applied_speed <= '0;
      target_speed  <= '0;
      target_dir    <= 1'b1;
      cur_dir       <= 1'b1;
      ramp_flag     <= 1'b0;
      rev_flag      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (s_fire) begin
        applied_speed <= applied_speed_next;
        target_speed  <= target_speed_next;
        target_dir    <= target_dir_next;
        cur_dir       <= cur_dir_next;
        ramp_flag     <= ramp_flag_next;
        rev_flag      <= rev_flag_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      res <= res_next;
    end
  end

  assign m_tdata = M_TDATA_W'(res);

  `SRRU_ASSERT(a_setdir_at_zero,
    m_tvalid && res.cmd.set_direction |-> (res.speed == '0) && res.cmd.stop_now)
  `SRRU_ASSERT(a_run_xor_profiled_stop,
    m_tvalid |-> !(res.cmd.run_at_rate && res.cmd.stop_profiled))
  `SRRU_ASSERT(a_disable_clears_speed,
    m_tvalid && res.cmd.disable_driver |-> (res.speed == '0) && (res.target == '0))
  `SRRU_ASSERT(a_state_holds_without_transfer,
    !s_fire |=> $stable(applied_speed) && $stable(target_speed) && $stable(cur_dir))
  `SRRU_ASSERT(a_result_matches_state,
    s_fire |=> (res.speed == applied_speed) && (res.direction == cur_dir))

endmodule
